### hw/rtl/qam_soft_demapper_assert.svh
// ----------------------------------------------------------------------------
// qam_soft_demapper_assert.svh
// Assertion macros for the soft demapper RTL.
// ----------------------------------------------------------------------------
`ifndef QAM_SOFT_DEMAPPER_ASSERT_SVH
`define QAM_SOFT_DEMAPPER_ASSERT_SVH
`ifndef SYNTHESIS
// check while out of reset
`define QSD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("qsd assertion failed");
// check at every edge, reset included
`define QSD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("qsd assertion failed");
`else
`define QSD_ASSERT(lbl, clk, rstn, prop)
`define QSD_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### hw/rtl/qsd_pkg.sv
// ----------------------------------------------------------------------------
// qsd_pkg
// Types, level tables and helpers for the QAM soft demapper.
// ----------------------------------------------------------------------------
`default_nettype none
package qsd_pkg;

  typedef enum logic [1:0] {
    MOD_QPSK  = 2'd0,
    MOD_QAM16 = 2'd1,
    MOD_QAM64 = 2'd2,
    MOD_QAM256 = 2'd3
  } mod_t;

  localparam logic REG_MOD_ORDER = 1'b0;
  localparam logic REG_INV_NV    = 1'b1;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last_in;
  } in_t;

  typedef struct packed {
    logic signed [23:0] llr_first;
    logic signed [23:0] llr_second;
    logic signed [23:0] llr_third;
    logic signed [23:0] llr_fourth;
    logic [2:0]         bit_count;
    logic               last_out;
  } out_t;

  typedef logic signed [27:0] met_t;
  typedef logic [30:0]        dsq_t;

  localparam logic signed [15:0] LVL64 [0:7] = '{
    -16'sd1896, -16'sd632, -16'sd3160, -16'sd4424,
    16'sd1896, 16'sd632, 16'sd3160, 16'sd4424};

  localparam logic signed [15:0] LVL256 [0:15] = '{
    -16'sd1571, -16'sd2199, -16'sd942, -16'sd314,
    -16'sd3456, -16'sd2827, -16'sd4084, -16'sd4712,
    16'sd1571, 16'sd2199, 16'sd942, 16'sd314,
    16'sd3456, 16'sd2827, 16'sd4084, 16'sd4712};

  localparam logic [9:0] JAC_CORR [0:15] = '{
    10'd590, 10'd396, 10'd258, 10'd164, 10'd103, 10'd63, 10'd39, 10'd24,
    10'd14, 10'd9, 10'd5, 10'd3, 10'd2, 10'd1, 10'd1, 10'd0};

  localparam logic signed [15:0] QAM16_OFFSET = 16'sd648;
  localparam logic signed [28:0] CLAMP64      = 29'sd10240000;
  localparam logic signed [28:0] LLR_MAX      = 29'sd8388607;
  localparam logic signed [28:0] LLR_MIN      = -29'sd8388608;
  localparam logic signed [27:0] CLAMP256     = 28'sd10240;

  function automatic dsq_t dist_sq(input logic signed [15:0] s,
                                   input logic signed [15:0] lvl);
    logic signed [16:0] d;
    logic [15:0]        a;
    logic [31:0]        sq;
    d  = {s[15], s} - {lvl[15], lvl};
    a  = d[16] ? 16'(-d) : d[15:0];
    sq = a * a;
    return sq[30:0];
  endfunction

  function automatic met_t jac(input met_t a, input met_t b);
    met_t        mx;
    logic [28:0] df;
    mx = (a > b) ? a : b;
    df = (a > b) ? 29'({a[27], a} - {b[27], b}) : 29'({b[27], b} - {a[27], a});
    if (df < 29'd8192) begin
      mx = mx + met_t'({18'd0, JAC_CORR[df[12:9]]});
    end
    return mx;
  endfunction

  function automatic dsq_t min2(input dsq_t a, input dsq_t b);
    return (b < a) ? b : a;
  endfunction

  function automatic logic [2:0] idx64(input int b, input logic x, input logic [1:0] j);
    logic [2:0] r;
    case (b)
      0: r = {x, j};
      1: r = {j[1], x, j[0]};
      default: r = {j, x};
    endcase
    return r;
  endfunction

  function automatic logic [3:0] idx256(input int b, input logic x, input logic [2:0] j);
    logic [3:0] r;
    case (b)
      0: r = {x, j};
      1: r = {j[2], x, j[1:0]};
      2: r = {j[2:1], x, j[0]};
      default: r = {j, x};
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/qam_soft_demapper.sv
// ----------------------------------------------------------------------------
// qam_soft_demapper
// Per-axis soft bit demapper for QPSK, 16, 64 and 256-QAM.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  in      | in_valid / in_stall   | in_data (sample, last_in)
//  out     | out_valid / out_stall | out_data (four LLRs, bit_count, last_out)
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  One request per cycle while the output is not stalled; stages are squares,
//  metric multiply, three Jacobian fold steps and output register.
//  The 64-QAM fold chain sets the depth; each stage holds one multiply or
//  one compare-add.
//  Synchronous active-low reset clears valids and sets configuration to 16-QAM, k = 65536.
//  A stalled output freezes the whole pipeline; in_stall follows it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "qam_soft_demapper_assert.svh"
module qam_soft_demapper (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire qsd_pkg::in_t   in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output qsd_pkg::out_t       out_data,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic           cfg_index,
  input  wire logic [23:0]    cfg_data
);
  import qsd_pkg::*;

  mod_t        mod_r;
  logic [23:0] k_r;
  logic        adv;
  logic [4:0]  vld_r;
  logic        out_vld_r;
  out_t        out_r, out_nxt;

  logic signed [15:0] smp_r [0:4];
  logic               lst_r [0:4];

  dsq_t d64_r  [0:7];
  dsq_t d256_r [0:15];
  met_t m_r    [0:7];
  met_t m3_r   [0:7];
  met_t m4_r   [0:7];
  dsq_t mn4_r  [0:3][0:1][0:1];
  dsq_t mn_r   [0:3][0:1];
  logic signed [31:0] df_r   [0:3];
  logic signed [56:0] prod_r [0:3];
  met_t acc3_r [0:2][0:1];
  met_t acc4_r [0:2][0:1];
  met_t acc5_r [0:2][0:1];

  assign cfg_ready = 1'b1;
  assign adv       = !(out_vld_r && out_stall);
  assign in_stall  = !adv;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= MOD_QAM16;
      k_r   <= 24'd65536;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MOD_ORDER: mod_r <= mod_t'(cfg_data[1:0]);
        REG_INV_NV:    k_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r     <= {vld_r[3:0], in_valid};
      out_vld_r <= vld_r[4];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      smp_r[0] <= in_data.sample;
      lst_r[0] <= in_data.last_in;
      for (int i = 1; i < 5; i++) begin
        smp_r[i] <= smp_r[i-1];
        lst_r[i] <= lst_r[i-1];
      end
      for (int i = 0; i < 8; i++) begin
        d64_r[i] <= dist_sq(in_data.sample, LVL64[i]);
      end
      for (int i = 0; i < 16; i++) begin
        d256_r[i] <= dist_sq(in_data.sample, LVL256[i]);
      end
      for (int i = 0; i < 8; i++) begin
        logic [54:0] p;
        logic [55:0] pr;
        p  = d64_r[i] * k_r;
        pr = {1'b0, p} + 56'(1 << 29);
        m_r[i]  <= -$signed({2'b00, pr[55:30]});
        m3_r[i] <= m_r[i];
        m4_r[i] <= m3_r[i];
      end
      for (int b = 0; b < 4; b++) begin
        for (int x = 0; x < 2; x++) begin
          for (int h = 0; h < 2; h++) begin
            mn4_r[b][x][h] <= min2(
              min2(d256_r[idx256(b, x[0], 3'(h*4))], d256_r[idx256(b, x[0], 3'(h*4+1))]),
              min2(d256_r[idx256(b, x[0], 3'(h*4+2))], d256_r[idx256(b, x[0], 3'(h*4+3))]));
          end
          mn_r[b][x] <= min2(mn4_r[b][x][0], mn4_r[b][x][1]);
        end
        df_r[b]   <= $signed({1'b0, mn_r[b][1]}) - $signed({1'b0, mn_r[b][0]});
        prod_r[b] <= 57'(df_r[b] * $signed({1'b0, k_r}));
      end
      for (int b = 0; b < 3; b++) begin
        for (int x = 0; x < 2; x++) begin
          acc3_r[b][x] <= jac(m_r[idx64(b, x[0], 2'd0)], m_r[idx64(b, x[0], 2'd1)]);
          acc4_r[b][x] <= jac(acc3_r[b][x], m3_r[idx64(b, x[0], 2'd2)]);
          acc5_r[b][x] <= jac(acc4_r[b][x], m4_r[idx64(b, x[0], 2'd3)]);
        end
      end
      out_r <= out_nxt;
    end
  end

  always_comb begin
    logic signed [17:0] t1, t2;
    logic signed [15:0] q1, q2;
    logic [15:0]        a;
    logic signed [23:0] l64  [0:2];
    logic signed [23:0] l256 [0:3];
    logic signed [28:0] d;
    logic signed [57:0] t;
    logic signed [27:0] r;
    a  = smp_r[4][15] ? 16'(-smp_r[4]) : smp_r[4];
    t1 = -$signed({{2{smp_r[4][15]}}, smp_r[4]}) + 18'sd2;
    t2 = -$signed({2'b00, a}) + 18'sd2;
    q1 = t1[17:2];
    q2 = t2[17:2] + QAM16_OFFSET;
    for (int b = 0; b < 3; b++) begin
      d = {acc5_r[b][0][27], acc5_r[b][0]} - {acc5_r[b][1][27], acc5_r[b][1]};
      if (d > CLAMP64) d = CLAMP64;
      else if (d < -CLAMP64) d = -CLAMP64;
      if (d > LLR_MAX) d = LLR_MAX;
      else if (d < LLR_MIN) d = LLR_MIN;
      l64[b] = d[23:0];
    end
    for (int b = 0; b < 4; b++) begin
      t = {prod_r[b][56], prod_r[b]} + 58'sd536870912;
      r = t[57:30];
      if (r > CLAMP256) r = CLAMP256;
      else if (r < -CLAMP256) r = -CLAMP256;
      l256[b] = r[23:0];
    end
    out_nxt          = '0;
    out_nxt.last_out = lst_r[4];
    case (mod_r)
      MOD_QPSK: begin
        out_nxt.bit_count = 3'd1;
        out_nxt.llr_first = 24'(q1);
      end
      MOD_QAM16: begin
        out_nxt.bit_count  = 3'd2;
        out_nxt.llr_first  = 24'(q1);
        out_nxt.llr_second = 24'(q2);
      end
      MOD_QAM64: begin
        out_nxt.bit_count  = 3'd3;
        out_nxt.llr_first  = l64[0];
        out_nxt.llr_second = l64[1];
        out_nxt.llr_third  = l64[2];
      end
      default: begin
        out_nxt.bit_count  = 3'd4;
        out_nxt.llr_first  = l256[0];
        out_nxt.llr_second = l256[1];
        out_nxt.llr_third  = l256[2];
        out_nxt.llr_fourth = l256[3];
      end
    endcase
  end

  `QSD_ASSERT(a_enter, clk, rst_n, (in_valid && !in_stall) |=> vld_r[0])
  `QSD_ASSERT(a_count, clk, rst_n, out_valid |-> (out_data.bit_count == 3'({1'b0, mod_r}) + 3'd1))
  `QSD_ASSERT(a_unused, clk, rst_n, (out_valid && out_data.bit_count < 3'd3) |-> (out_data.llr_third == 24'sd0 && out_data.llr_fourth == 24'sd0))
  `QSD_ASSERT_ALWAYS(a_rst, clk, !rst_n |=> !out_valid)

endmodule
`default_nettype wire

### verif/qam_soft_demapper_tb.sv
// ----------------------------------------------------------------------------
// qam_soft_demapper_tb
// Drives axis samples through every constellation order and noise setting,
// computes the expected LLRs in a local demapper model and checks each
// result in order, under several sender and receiver idling phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module qam_soft_demapper_tb;
  import qsd_pkg::*;

  localparam int LATENCY    = 6;
  localparam int CYCLE_LIMIT = 600000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic [23:0] cfg_data;

  qam_soft_demapper DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct {
    logic signed [15:0] sample;
    logic               last;
    bit                 typed;
    out_t               llrs;
  } row_t;

  mod_t        cur_order;
  logic [23:0] cur_inv_nv;
  out_t        pending_llrs[$];
  int          errors;
  int          cycles;
  int          idle_pct;
  int          stall_pct;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("qam_soft_demapper_tb NOT OK");
      $finish;
    end
  end

  function automatic longint rshift_round(longint v, int sh);
    longint t;
    t = v + (longint'(1) << (sh - 1));
    if (t >= 0) return t >>> sh;
    return -(((-t) + (longint'(1) << sh) - 1) >>> sh);
  endfunction

  function automatic longint sq_dist(longint s, longint lv);
    longint d;
    d = s - lv;
    return d * d;
  endfunction

  function automatic longint gauss_metric(longint s, longint lv, longint k);
    return -((sq_dist(s, lv) * k + (longint'(1) << 29)) >>> 30);
  endfunction

  function automatic longint log_sum(longint a, longint b);
    longint mx;
    longint df;
    logic [9:0] corr [0:15];
    corr = '{10'd590, 10'd396, 10'd258, 10'd164, 10'd103, 10'd63, 10'd39, 10'd24,
             10'd14, 10'd9, 10'd5, 10'd3, 10'd2, 10'd1, 10'd1, 10'd0};
    mx = a > b ? a : b;
    df = a > b ? a - b : b - a;
    if (df < 8192) mx += corr[df >> 9];
    return mx;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic out_t demap(logic signed [15:0] sample, logic last);
    longint s;
    longint k;
    longint llr[4];
    longint m[8];
    longint acc[2];
    bit seen[2];
    longint mn[2];
    longint d2;
    int bitv;
    int lv64[8];
    int lv256[16];
    out_t r;
    lv64 = '{-1896, -632, -3160, -4424, 1896, 632, 3160, 4424};
    lv256 = '{-1571, -2199, -942, -314, -3456, -2827, -4084, -4712,
              1571, 2199, 942, 314, 3456, 2827, 4084, 4712};
    s = sample;
    k = cur_inv_nv;
    llr = '{0, 0, 0, 0};
    case (cur_order)
      MOD_QPSK: begin
        r.bit_count = 3'd1;
        llr[0] = rshift_round(-s, 2);
      end
      MOD_QAM16: begin
        r.bit_count = 3'd2;
        llr[0] = rshift_round(-s, 2);
        llr[1] = rshift_round(-(s < 0 ? -s : s), 2) + 648;
      end
      MOD_QAM64: begin
        r.bit_count = 3'd3;
        for (int i = 0; i < 8; i++) m[i] = gauss_metric(s, lv64[i], k);
        for (int b = 0; b < 3; b++) begin
          seen = '{0, 0};
          acc = '{0, 0};
          for (int i = 0; i < 8; i++) begin
            bitv = (i >> (2 - b)) & 1;
            acc[bitv] = seen[bitv] ? log_sum(acc[bitv], m[i]) : m[i];
            seen[bitv] = 1;
          end
          llr[b] = clip(clip(acc[0] - acc[1], -10240000, 10240000), -8388608, 8388607);
        end
      end
      default: begin
        r.bit_count = 3'd4;
        for (int b = 0; b < 4; b++) begin
          mn = '{64'h7fffffffffffffff, 64'h7fffffffffffffff};
          for (int i = 0; i < 16; i++) begin
            bitv = (i >> (3 - b)) & 1;
            d2 = sq_dist(s, lv256[i]);
            if (d2 < mn[bitv]) mn[bitv] = d2;
          end
          llr[b] = clip(rshift_round((mn[1] - mn[0]) * k, 30), -10240, 10240);
        end
      end
    endcase
    r.llr_first  = llr[0][23:0];
    r.llr_second = llr[1][23:0];
    r.llr_third  = llr[2][23:0];
    r.llr_fourth = llr[3][23:0];
    r.last_out   = last;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_llrs.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = pending_llrs.pop_front();
        if (out_data.llr_first != want.llr_first)
          report_mismatch("llr_first", out_data.llr_first, want.llr_first);
        if (out_data.llr_second != want.llr_second)
          report_mismatch("llr_second", out_data.llr_second, want.llr_second);
        if (out_data.llr_third != want.llr_third)
          report_mismatch("llr_third", out_data.llr_third, want.llr_third);
        if (out_data.llr_fourth != want.llr_fourth)
          report_mismatch("llr_fourth", out_data.llr_fourth, want.llr_fourth);
        if (out_data.bit_count != want.bit_count)
          report_mismatch("bit_count", out_data.bit_count, want.bit_count);
        if (out_data.last_out != want.last_out)
          report_mismatch("last_out", out_data.last_out, want.last_out);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic write_reg(logic idx, logic [23:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_MOD_ORDER) cur_order = mod_t'(value[1:0]);
    else cur_inv_nv = value;
  endtask

  task automatic drain();
    while (pending_llrs.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic send_sample(logic signed [15:0] sample, logic last, bit typed, out_t want);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.sample  <= sample;
    in_data.last_in <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_llrs.push_back(typed ? want : demap(sample, last));
  endtask

  task automatic random_burst(int count);
    logic signed [15:0] s;
    out_t none;
    none = '0;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0: s = 16'($urandom);
        1: s = $signed(16'($urandom_range(12000))) - 16'sd6000;
        2: s = ($urandom_range(1) ? 16'sd4712 : -16'sd4712)
               + $signed(16'($urandom_range(400))) - 16'sd200;
        default: s = $signed(16'($urandom_range(2000))) - 16'sd1000;
      endcase
      send_sample(s, $urandom_range(7) == 0, 1'b0, none);
    end
    in_valid <= 1'b0;
  endtask

  row_t directed[$];

  function automatic out_t typed_llrs(int a, int b, int c, int d, int n, logic last);
    out_t r;
    r.llr_first = 24'(a);
    r.llr_second = 24'(b);
    r.llr_third = 24'(c);
    r.llr_fourth = 24'(d);
    r.bit_count = 3'(n);
    r.last_out = last;
    return r;
  endfunction

  initial begin
    logic [23:0] nv_set[5];
    out_t none;
    none = '0;
    nv_set = '{24'd0, 24'hffffff, 24'd65536, 24'd1000, 24'd4000000};
    idle_pct = 0;
    stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_MOD_ORDER;
    cfg_data = '0;
    cur_order = MOD_QAM16;
    cur_inv_nv = 24'd65536;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset state: 16-QAM, typed expectations for the first four samples, model for the rest
    directed.push_back('{16'sd0, 1'b0, 1'b1, typed_llrs(0, 648, 0, 0, 2, 1'b0)});
    directed.push_back('{16'sd32767, 1'b1, 1'b1, typed_llrs(-8192, -7544, 0, 0, 2, 1'b1)});
    directed.push_back('{-16'sd32768, 1'b0, 1'b1, typed_llrs(8192, -7544, 0, 0, 2, 1'b0)});
    directed.push_back('{16'sd4, 1'b1, 1'b1, typed_llrs(-1, 647, 0, 0, 2, 1'b1)});
    directed.push_back('{-16'sd2, 1'b0, 1'b0, none});
    directed.push_back('{16'sd2, 1'b0, 1'b0, none});
    directed.push_back('{16'sd632, 1'b1, 1'b0, none});
    foreach (directed[i])
      send_sample(directed[i].sample, directed[i].last, directed[i].typed, directed[i].llrs);
    in_valid <= 1'b0;
    drain();

    for (int o = 0; o < 4; o++) begin
      write_reg(REG_MOD_ORDER, 24'(o));
      for (int n = 0; n < 5; n++) begin
        write_reg(REG_INV_NV, nv_set[n]);
        foreach (directed[i])
          send_sample(directed[i].sample, directed[i].last, 1'b0, none);
        send_sample(16'sd4712, 1'b0, 1'b0, none);
        send_sample(-16'sd4424, 1'b1, 1'b0, none);
        in_valid <= 1'b0;
        drain();
      end
    end

    for (int p = 0; p < 16; p++) begin
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 64; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 64; end
        default: begin idle_pct = 7; stall_pct = 7; end
      endcase
      write_reg(REG_MOD_ORDER, 24'($urandom_range(3)));
      write_reg(REG_INV_NV, (p % 5 == 4) ? nv_set[$urandom_range(4)]
                : 24'($urandom_range(24'hffffff)));
      random_burst(76);
      drain();
    end

    stall_pct = 0;
    drain();
    if (errors == 0) begin
      $display("qam_soft_demapper_tb OK");
    end else begin
      $display("qam_soft_demapper_tb NOT OK");
    end
    $finish;
  end
endmodule
